// ----- sv/sadm_pkg.sv -----
// Shared widths, constants and register indexes of the stereo mixer with DC blocker.
package sadm_pkg;

    // Field and state widths
    localparam int FRAC_W   = 17;
    localparam int PSG_W    = 20;
    localparam int DAC_W    = 9;
    localparam int ALPHA_W  = 24;
    localparam int VOL_W    = 10;
    localparam int SAMPLE_W = 16;
    localparam int FILT_W   = 28;

    // Feedback coefficient fraction bits
    localparam int ALPHA_FRACTION_BITS = 24;

    // Shared multiplier: signed MUL_W x MUL_W, full product
    localparam int MUL_W  = 30;
    localparam int PROD_W = 2 * MUL_W;

    // Working accumulators and magnitude of gain/volume quotients
    localparam int ACC_W = 30;
    localparam int Q_W   = 20;

    // Beeper level rounding
    localparam int EAR_SHIFT = 15;
    localparam int MIC_SHIFT = 17;
    localparam int EAR_BIAS  = 1 << (EAR_SHIFT - 1);
    localparam int MIC_BIAS  = 1 << (MIC_SHIFT - 1);
    localparam int BEEP_W    = FILT_W - EAR_SHIFT + 2;

    // Mix terms in Q.8
    localparam int BEEP_SHIFT = 8;
    localparam int DAC_SHIFT  = 10;
    localparam int DAC_MID    = 256;

    // Reciprocals for exact floor division by 257, 200 and 1000
    // floor(psg*256/257) = (psg * RECIP_257) >> PSG_SHIFT
    localparam logic [MUL_W-1:0] RECIP_257 = 30'd267390961;
    localparam int               PSG_SHIFT = 28;
    // floor(n/200) = ((n >> 3) * RECIP_25) >> GAIN_SHIFT
    localparam logic [MUL_W-1:0] RECIP_25   = 30'd21474837;
    localparam int               GAIN_SHIFT = 29;
    // floor(n/1000) = ((n >> 3) * RECIP_125) >> VOL_SHIFT
    localparam logic [MUL_W-1:0] RECIP_125 = 30'd68719477;
    localparam int               VOL_SHIFT = 33;
    localparam int               DIV_BIAS  = 999;

    // Reset values
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 24'd16774142;
    localparam logic [VOL_W-1:0]   VOL_MAX     = 10'd1000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_ALPHA     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_MILLI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEAKER_ONLY = 2'd2;

endpackage

// ----- sv/stereo_audio_mixer_dc_block.sv -----
// Stereo audio mixer: beeper DC blockers, PSG/DAC mix, gain, volume and saturation.
//
//  Channel   Direction  Beat contents
//  -------   ---------  ---------------------------------------------------------
//  s_        in         ear, mic fractions, left/right PSG levels, left/right DAC sums
//  m_        out        left and right saturated 16-bit samples
//  cfg_      in         register index and write data, taken only while the sequencer idles
//
//  One input beat passes eleven busy steps of the sequencer that feeds a single 30x30
//  signed multiplier (two filter feedback products, then per side the PSG divide by 257,
//  the gain divide by 200, the volume product and the divide by 1000), then the step
//  that loads the output register and the idle step before the next accept.
//  Reset (aresetn low at a clock edge) restores the register defaults and clears the
//  filter history; no clearing pass is needed.
//  The next beat is accepted while a finished sample still waits on m_; the sequencer
//  holds in its last step only if that sample is still untaken when the next is ready.
module stereo_audio_mixer_dc_block
    import sadm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [16:0] ear_fraction, [33:17] mic_fraction, [53:34] psg_left,
    // [73:54] psg_right, [82:74] dac_left, [91:83] dac_right, [95:92] zero
    input  logic [95:0]          s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] left_word, [31:16] right_word
    output logic [31:0]          m_tdata,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ALPHA_W-1:0]   cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EAR,
        S_MIC,
        S_PSGL,
        S_PSGR,
        S_GAINL,
        S_GAINR,
        S_VOLL,
        S_VOLR,
        S_DIVL,
        S_DIVR,
        S_RES,
        S_OUT
    } state_t;

    state_t state_reg;

    // Configuration
    logic [ALPHA_W-1:0] alpha_reg;
    logic [VOL_W-1:0]   vol_reg;
    logic               spk_reg;

    // Filter history
    logic        [FRAC_W-1:0] ear_in_reg;
    logic        [FRAC_W-1:0] mic_in_reg;
    logic signed [FILT_W-1:0] ear_out_reg;
    logic signed [FILT_W-1:0] mic_out_reg;

    // Captured input beat
    logic [FRAC_W-1:0] ear_x_reg;
    logic [FRAC_W-1:0] mic_x_reg;
    logic [PSG_W-1:0]  psg_l_reg;
    logic [PSG_W-1:0]  psg_r_reg;
    logic [DAC_W-1:0]  dac_l_reg;
    logic [DAC_W-1:0]  dac_r_reg;

    // Datapath
    logic signed [PROD_W-1:0]           prod_reg;
    logic signed [FILT_W-EAR_SHIFT:0]   ear_lvl_reg;
    logic signed [BEEP_W-1:0]           beep_reg;
    logic signed [ACC_W-1:0]            left_acc_reg;
    logic signed [ACC_W-1:0]            right_acc_reg;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    assign s_tready  = (state_reg == S_IDLE);
    // Take register writes only between beats, so no filter step races an alpha write
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // One-pole DC blocker: y = (x - x_prev) * 256 + floor(alpha * y_prev), saturated
    function automatic logic signed [FILT_W-1:0] filt_out(
        input logic        [FRAC_W-1:0] x,
        input logic        [FRAC_W-1:0] last,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W:0] dx;
        logic signed [PROD_W:0] dl;
        logic signed [PROD_W:0] y;
        logic signed [PROD_W:0] hi;
        logic signed [PROD_W:0] lo;
        dx = (PROD_W+1)'($signed({1'b0, x}));
        dl = (PROD_W+1)'($signed({1'b0, last}));
        hi = (PROD_W+1)'((1 << (FILT_W - 1)) - 1);
        lo = -hi - (PROD_W+1)'(1);
        y  = ((dx - dl) <<< 8) + (PROD_W+1)'(p >>> ALPHA_FRACTION_BITS);
        if (y > hi) begin
            y = hi;
        end else if (y < lo) begin
            y = lo;
        end
        return y[FILT_W-1:0];
    endfunction

    // Filter stage: the ear product is consumed in S_MIC, the mic product in S_PSGL
    logic        [FRAC_W-1:0]       filt_x;
    logic        [FRAC_W-1:0]       filt_last;
    logic signed [FILT_W-1:0]       filt_y;
    logic signed [FILT_W:0]         ear_round;
    logic signed [FILT_W:0]         mic_round;
    logic signed [FILT_W-MIC_SHIFT:0] mic_lvl;
    logic signed [BEEP_W-1:0]       beep_next;

    assign filt_x    = (state_reg == S_MIC) ? ear_x_reg  : mic_x_reg;
    assign filt_last = (state_reg == S_MIC) ? ear_in_reg : mic_in_reg;
    assign filt_y    = filt_out(filt_x, filt_last, prod_reg);

    // Round half up: ear = y*512, mic = y*128
    assign ear_round = (FILT_W+1)'(filt_y) + (FILT_W+1)'(EAR_BIAS);
    assign mic_round = (FILT_W+1)'(filt_y) + (FILT_W+1)'(MIC_BIAS);
    assign mic_lvl   = mic_round[FILT_W:MIC_SHIFT];
    assign beep_next = spk_reg ? '0 : (BEEP_W)'(ear_lvl_reg) + (BEEP_W)'(mic_lvl);

    // Operand side: accumulator that feeds the multiplier in this step
    logic signed [ACC_W-1:0] sel_acc;
    logic                    sel_neg;
    logic        [ACC_W-1:0] sel_abs;
    logic        [ACC_W-1:0] gain_t;
    logic        [ACC_W-1:0] div_t;

    assign sel_acc = (state_reg inside {S_GAINL, S_VOLL, S_DIVL}) ? left_acc_reg
                                                                  : right_acc_reg;
    assign sel_neg = sel_acc[ACC_W-1];
    assign sel_abs = sel_neg ? ACC_W'(-sel_acc) : ACC_W'(sel_acc);
    // |m| * 23 by shift and add
    assign gain_t  = (sel_abs << 4) + (sel_abs << 2) + (sel_abs << 1) + sel_abs;
    // floor of a negative value divides |x| + 999
    assign div_t   = sel_abs + (sel_neg ? ACC_W'(DIV_BIAS) : '0);

    logic signed [MUL_W-1:0] op_a;
    logic signed [MUL_W-1:0] op_b;

    always_comb begin
        case (state_reg)
            S_EAR: begin
                op_a = {{(MUL_W-ALPHA_W){1'b0}}, alpha_reg};
                op_b = {{(MUL_W-FILT_W){ear_out_reg[FILT_W-1]}}, ear_out_reg};
            end
            S_MIC: begin
                op_a = {{(MUL_W-ALPHA_W){1'b0}}, alpha_reg};
                op_b = {{(MUL_W-FILT_W){mic_out_reg[FILT_W-1]}}, mic_out_reg};
            end
            S_PSGL: begin
                op_a = {{(MUL_W-PSG_W){1'b0}}, psg_l_reg};
                op_b = RECIP_257;
            end
            S_PSGR: begin
                op_a = {{(MUL_W-PSG_W){1'b0}}, psg_r_reg};
                op_b = RECIP_257;
            end
            S_GAINL, S_GAINR: begin
                op_a = {{(MUL_W-ACC_W+3){1'b0}}, gain_t[ACC_W-1:3]};
                op_b = RECIP_25;
            end
            S_VOLL, S_VOLR: begin
                op_a = (MUL_W)'(sel_acc);
                op_b = {{(MUL_W-VOL_W){1'b0}}, vol_reg};
            end
            S_DIVL, S_DIVR: begin
                op_a = {{(MUL_W-ACC_W+3){1'b0}}, div_t[ACC_W-1:3]};
                op_b = RECIP_125;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Result side: the product of the previous step
    logic signed [ACC_W-1:0] cons_acc;
    logic                    cons_neg;
    logic        [PSG_W-1:0] psg_q;
    logic        [DAC_W-1:0] dac_sel;
    logic signed [ACC_W-1:0] mix_m;
    logic        [Q_W-1:0]   g_q;
    logic signed [ACC_W-1:0] g_ext;
    logic signed [ACC_W-1:0] g_val;
    logic        [Q_W-1:0]   v_q;
    logic signed [ACC_W-1:0] v_ext;
    logic signed [ACC_W-1:0] v_val;
    logic signed [ACC_W-1:0] v_sat;
    logic signed [ACC_W-1:0] prod_x;

    assign cons_acc = (state_reg inside {S_GAINR, S_DIVR}) ? left_acc_reg : right_acc_reg;
    assign cons_neg = cons_acc[ACC_W-1];

    // M = beep*256 + floor(psg*256/257) + (dac - 256)*1024
    assign psg_q   = prod_reg[PSG_SHIFT +: PSG_W];
    assign dac_sel = (state_reg == S_PSGR) ? dac_l_reg : dac_r_reg;
    assign mix_m   = ((ACC_W)'(beep_reg) <<< BEEP_SHIFT)
                   + $signed({{(ACC_W-PSG_W){1'b0}}, psg_q})
                   + (($signed({{(ACC_W-DAC_W){1'b0}}, dac_sel}) - (ACC_W)'(DAC_MID))
                      <<< DAC_SHIFT);

    // Gain truncates toward zero: restore the sign of M
    assign g_q   = prod_reg[GAIN_SHIFT +: Q_W];
    assign g_ext = $signed({{(ACC_W-Q_W){1'b0}}, g_q});
    assign g_val = cons_neg ? -g_ext : g_ext;

    assign prod_x = prod_reg[ACC_W-1:0];

    // Volume divide floors: negative values were biased before the divide
    assign v_q   = prod_reg[VOL_SHIFT +: Q_W];
    assign v_ext = $signed({{(ACC_W-Q_W){1'b0}}, v_q});
    assign v_val = cons_neg ? -v_ext : v_ext;

    always_comb begin
        if (v_val > (ACC_W)'((1 << (SAMPLE_W - 1)) - 1)) begin
            v_sat = (ACC_W)'((1 << (SAMPLE_W - 1)) - 1);
        end else if (v_val < -(ACC_W)'(1 << (SAMPLE_W - 1))) begin
            v_sat = -(ACC_W)'(1 << (SAMPLE_W - 1));
        end else begin
            v_sat = v_val;
        end
    end

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;

        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            alpha_reg    <= ALPHA_RESET;
            vol_reg      <= VOL_MAX;
            spk_reg      <= 1'b0;
            ear_in_reg   <= '0;
            mic_in_reg   <= '0;
            ear_out_reg  <= '0;
            mic_out_reg  <= '0;
        end else begin
            // Raise the output beat when the sequencer loads it, drop it once taken
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        ear_x_reg <= s_tdata[16:0];
                        mic_x_reg <= s_tdata[33:17];
                        psg_l_reg <= s_tdata[53:34];
                        psg_r_reg <= s_tdata[73:54];
                        dac_l_reg <= s_tdata[82:74];
                        dac_r_reg <= s_tdata[91:83];
                        state_reg <= S_EAR;
                    end
                end
                S_EAR: begin
                    state_reg <= S_MIC;
                end
                S_MIC: begin
                    ear_out_reg <= filt_y;
                    ear_in_reg  <= ear_x_reg;
                    ear_lvl_reg <= ear_round[FILT_W:EAR_SHIFT];
                    state_reg   <= S_PSGL;
                end
                S_PSGL: begin
                    mic_out_reg <= filt_y;
                    mic_in_reg  <= mic_x_reg;
                    beep_reg    <= beep_next;
                    state_reg   <= S_PSGR;
                end
                S_PSGR: begin
                    left_acc_reg <= mix_m;
                    state_reg    <= S_GAINL;
                end
                S_GAINL: begin
                    right_acc_reg <= mix_m;
                    state_reg     <= S_GAINR;
                end
                S_GAINR: begin
                    left_acc_reg <= g_val;
                    state_reg    <= S_VOLL;
                end
                S_VOLL: begin
                    right_acc_reg <= g_val;
                    state_reg     <= S_VOLR;
                end
                S_VOLR: begin
                    left_acc_reg <= prod_x;
                    state_reg    <= S_DIVL;
                end
                S_DIVL: begin
                    right_acc_reg <= prod_x;
                    state_reg     <= S_DIVR;
                end
                S_DIVR: begin
                    left_acc_reg <= v_sat;
                    state_reg    <= S_RES;
                end
                S_RES: begin
                    right_acc_reg <= v_sat;
                    state_reg     <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_tdata_reg  <= {right_acc_reg[SAMPLE_W-1:0],
                                         left_acc_reg[SAMPLE_W-1:0]};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Register writes; an alpha write clears the filter history
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DC_ALPHA: begin
                        alpha_reg   <= cfg_data;
                        ear_in_reg  <= '0;
                        mic_in_reg  <= '0;
                        ear_out_reg <= '0;
                        mic_out_reg <= '0;
                    end
                    CFG_VOLUME_MILLI: begin
                        vol_reg <= (cfg_data[VOL_W-1:0] > VOL_MAX) ? VOL_MAX
                                                                    : cfg_data[VOL_W-1:0];
                    end
                    CFG_SPEAKER_ONLY: begin
                        spk_reg <= cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again while the sequencer is busy");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("output beat raised outside the output step");

    a_alpha_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && cfg_index == CFG_DC_ALPHA |=>
        ear_out_reg == '0 && mic_out_reg == '0 && ear_in_reg == '0 && mic_in_reg == '0)
        else $error("alpha write did not clear the filter history");

    a_vol_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vol_reg <= VOL_MAX)
        else $error("volume register above full scale");

endmodule

// ----- dv/stereo_audio_mixer_dc_block_test.sv -----
// Self-checking testbench of the stereo mixer with beeper DC blockers.
module stereo_audio_mixer_dc_block_test
    import sadm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Register index the block does not decode; a write to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int N_DIRECTED   = 20;
    localparam int N_PHASES     = 8;
    localparam int PHASE_BEATS  = 175;
    // Settle well past one beat's pass through the block
    localparam int SETTLE_CYCLES = 40;

    // Sources of one stereo sample
    typedef struct {
        logic [FRAC_W-1:0] ear;
        logic [FRAC_W-1:0] mic;
        logic [PSG_W-1:0]  psg_l;
        logic [PSG_W-1:0]  psg_r;
        logic [DAC_W-1:0]  dac_l;
        logic [DAC_W-1:0]  dac_r;
    } mix_beat_t;

    // Directed row: sources, plus a hand-typed sample where one is known
    typedef struct {
        int ear;
        int mic;
        int psg_l;
        int psg_r;
        int dac_l;
        int dac_r;
        bit typed;
        int want_l;
        int want_r;
    } beat_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [95:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ALPHA_W-1:0]   cfg_data = '0;

    stereo_audio_mixer_dc_block dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mirror of the block's registers and filter history
    logic [ALPHA_W-1:0] mix_alpha = ALPHA_RESET;
    logic [VOL_W-1:0]   mix_volume = VOL_MAX;
    logic               mix_speaker_only = 1'b0;
    logic [FRAC_W-1:0]  ear_prev_in = '0;
    logic [FRAC_W-1:0]  mic_prev_in = '0;
    longint             ear_prev_out = 0;
    longint             mic_prev_out = 0;

    // Samples still owed by the block, oldest first
    logic [31:0] pending_samples [$];

    int mismatches = 0;
    int beats_sent = 0;
    int samples_checked = 0;
    int cfg_writes = 0;

    // Square-wave state of the random beeper sources
    bit ear_high = 1'b0;
    bit mic_high = 1'b0;
    int ear_run = 0;
    int mic_run = 0;

    // Receiver stall pattern state
    int ready_mode = 0;
    int mode_left = 0;
    int ready_phase = 0;
    int ready_hold = 0;

    beat_row_t directed_rows [N_DIRECTED] = '{
        // Silence straight after reset
        '{0, 0, 0, 0, 256, 256, 1'b1, 0, 0},
        // DAC extremes, lowest on the left and the out-of-range 511 on the right
        '{0, 0, 0, 0, 0, 511, 1'b1, -30146, 30028},
        // Full-scale PSG saturates high
        '{0, 0, 1048575, 0, 256, 0, 1'b1, 32767, -30146},
        '{0, 0, 0, 1048575, 511, 256, 1'b1, 30028, 32767},
        '{0, 0, 1048575, 1048575, 511, 511, 1'b1, 32767, 32767},
        // Beeper edges through the filters
        '{65536, 0, 0, 0, 256, 256, 1'b0, 0, 0},
        '{65536, 65536, 0, 0, 256, 256, 1'b0, 0, 0},
        '{0, 0, 0, 0, 256, 256, 1'b0, 0, 0},
        // Fractions above one
        '{131071, 131071, 0, 0, 256, 256, 1'b0, 0, 0},
        '{0, 131071, 12345, 54321, 300, 200, 1'b0, 0, 0},
        '{65536, 0, 257 * 765, 257 * 100, 256, 256, 1'b0, 0, 0},
        '{1, 1, 257, 514, 257, 255, 1'b0, 0, 0},
        '{65535, 65536, 0, 1048575, 255, 257, 1'b0, 0, 0},
        '{0, 0, 0, 0, 511, 0, 1'b0, 0, 0},
        '{65536, 0, 257 * 300, 257 * 300, 256, 256, 1'b0, 0, 0},
        '{0, 65536, 257 * 300, 257 * 300, 256, 256, 1'b0, 0, 0},
        '{65536, 0, 257 * 300, 257 * 300, 256, 256, 1'b0, 0, 0},
        '{0, 65536, 257 * 300, 257 * 300, 256, 256, 1'b0, 0, 0},
        // Large positive beeper step, then the swing back down
        '{131071, 131071, 0, 0, 0, 0, 1'b0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 1'b0, 0, 0}
    };

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // One step of a DC blocker, saturated to the filter width
    function automatic longint blocker_out(input logic [FRAC_W-1:0] x,
                                           input logic [FRAC_W-1:0] px,
                                           input longint py);
        longint fb;
        longint y;
        longint lim;
        lim = longint'(1) << (FILT_W - 1);
        fb = (longint'(mix_alpha) * py) >>> ALPHA_FRACTION_BITS;
        y = (longint'(x) - longint'(px)) * 256 + fb;
        if (y > lim - 1) y = lim - 1;
        if (y < -lim) y = -lim;
        return y;
    endfunction

    // Mix one side in Q.8, apply the 29.44 gain and the volume, saturate
    function automatic logic [SAMPLE_W-1:0] side_word(input longint beep,
                                                      input logic [PSG_W-1:0] psg,
                                                      input logic [DAC_W-1:0] dac);
        longint m;
        longint g;
        longint t;
        longint v;
        m = beep * 256 + (longint'(psg) * 256) / 257 + (longint'(dac) - DAC_MID) * 1024;
        g = (m * 23) / 200;
        t = g * longint'(mix_volume);
        v = (t >= 0) ? t / 1000 : -((-t + 999) / 1000);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[SAMPLE_W-1:0];
    endfunction

    // Advance the filters on one beat and return the stereo sample it yields
    task automatic mix_sample(input mix_beat_t b, output logic [31:0] word);
        longint ey;
        longint my;
        longint ear_lvl;
        longint mic_lvl;
        ey = blocker_out(b.ear, ear_prev_in, ear_prev_out);
        my = blocker_out(b.mic, mic_prev_in, mic_prev_out);
        ear_prev_in = b.ear;
        mic_prev_in = b.mic;
        ear_prev_out = ey;
        mic_prev_out = my;
        ear_lvl = (ey + EAR_BIAS) >>> EAR_SHIFT;
        mic_lvl = (my + MIC_BIAS) >>> MIC_SHIFT;
        // Speaker only: filters keep running, only their contribution drops
        if (mix_speaker_only) begin
            ear_lvl = 0;
            mic_lvl = 0;
        end
        word = {side_word(ear_lvl + mic_lvl, b.psg_r, b.dac_r),
                side_word(ear_lvl + mic_lvl, b.psg_l, b.dac_l)};
    endtask

    // Present one beat and hold it until taken; valid stays high for the caller
    task automatic send_beat(input mix_beat_t b, input bit typed, input logic [31:0] typed_word);
        logic [31:0] word;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, b.dac_r, b.dac_l, b.psg_r, b.psg_l, b.mic, b.ear};
        do @(posedge aclk); while (!s_tready);
        mix_sample(b, word);
        pending_samples.push_back(typed ? typed_word : word);
        beats_sent++;
    endtask

    // Drop valid for a number of cycles
    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    // Hold off the sender until every owed sample is out, then let the block settle
    task automatic drain;
        idle_sender(1);
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
        logic [VOL_W-1:0] vol;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DC_ALPHA: begin
                // Alpha write also wipes the filter history
                mix_alpha = data;
                ear_prev_in = '0;
                mic_prev_in = '0;
                ear_prev_out = 0;
                mic_prev_out = 0;
            end
            CFG_VOLUME_MILLI: begin
                vol = data[VOL_W-1:0];
                mix_volume = (vol > VOL_MAX) ? VOL_MAX : vol;
            end
            CFG_SPEAKER_ONLY: mix_speaker_only = data[0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Beeper source: mostly a square wave with a partial fraction on each edge
    task automatic beeper_value(inout bit high, inout int run, output logic [FRAC_W-1:0] v);
        if ($urandom_range(0, 9) < 2) begin
            v = FRAC_W'($urandom_range(0, 131071));
        end else if (run == 0) begin
            high = !high;
            run = $urandom_range(1, 12);
            v = FRAC_W'($urandom_range(0, 65536));
        end else begin
            run--;
            v = high ? 17'd65536 : 17'd0;
        end
    endtask

    function automatic logic [PSG_W-1:0] psg_value;
        case ($urandom_range(0, 3))
            0: return '0;
            1: return PSG_W'($urandom_range(0, 1048575));
            2: return PSG_W'(($urandom_range(0, 255) + $urandom_range(0, 255)
                              + $urandom_range(0, 255)) * 257);
            default: return PSG_W'(1048575 - $urandom_range(0, 15));
        endcase
    endfunction

    function automatic logic [DAC_W-1:0] dac_value;
        case ($urandom_range(0, 3))
            0: return 9'd256;
            1: return DAC_W'($urandom_range(0, 511));
            2: return DAC_W'($urandom_range(0, 255) + $urandom_range(0, 255));
            default: begin
                case ($urandom_range(0, 2))
                    0: return 9'd0;
                    1: return 9'd510;
                    default: return 9'd511;
                endcase
            end
        endcase
    endfunction

    task automatic random_beat(output mix_beat_t b);
        beeper_value(ear_high, ear_run, b.ear);
        beeper_value(mic_high, mic_run, b.mic);
        b.psg_l = psg_value();
        b.psg_r = psg_value();
        b.dac_l = dac_value();
        b.dac_r = dac_value();
    endtask

    // Receiver stall pattern: switch between free flow, coin flips, a fixed
    // duty cycle, and rare long stalls
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(50, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        ready_phase <= ready_phase + 1;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (ready_phase % 7) >= 3;
            default: begin
                if (ready_hold != 0) begin
                    ready_hold <= ready_hold - 1;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    ready_hold <= $urandom_range(5, 40);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Check every taken sample against the oldest owed one
    always @(posedge aclk) begin : take_sample
        logic [31:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_samples.size() == 0) begin
                report($sformatf("sample %08h with none owed", m_tdata));
            end else begin
                want = pending_samples.pop_front();
                if (m_tdata[15:0] !== want[15:0])
                    report($sformatf("left_word got %0d want %0d", $signed(m_tdata[15:0]),
                                     $signed(want[15:0])));
                if (m_tdata[31:16] !== want[31:16])
                    report($sformatf("right_word got %0d want %0d", $signed(m_tdata[31:16]),
                                     $signed(want[31:16])));
                samples_checked++;
            end
        end
    end

    initial begin : stimulus
        mix_beat_t b;
        int alpha;
        int vol;
        int spk;
        bit junk;
        int burst;
        bit free_flow;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows under reset register values
        foreach (directed_rows[i]) begin
            b.ear = FRAC_W'(directed_rows[i].ear);
            b.mic = FRAC_W'(directed_rows[i].mic);
            b.psg_l = PSG_W'(directed_rows[i].psg_l);
            b.psg_r = PSG_W'(directed_rows[i].psg_r);
            b.dac_l = DAC_W'(directed_rows[i].dac_l);
            b.dac_r = DAC_W'(directed_rows[i].dac_r);
            send_beat(b, directed_rows[i].typed,
                      {directed_rows[i].want_r[15:0], directed_rows[i].want_l[15:0]});
            idle_sender($urandom_range(0, 2));
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            junk = 1'b0;
            case (ph)
                0: begin alpha = 0;        vol = 1000; spk = 0; end
                1: begin alpha = 16777215; vol = 0;    spk = 0; end
                2: begin alpha = 16774142; vol = 1023; spk = 1; end
                3: begin
                    alpha = $urandom_range(0, 16777215);
                    vol = 1001;
                    spk = 0;
                    junk = 1'b1;
                end
                4: begin alpha = $urandom_range(16000000, 16777215); vol = 1; spk = 1; end
                5: begin alpha = 16777215; vol = 500; spk = 0; end
                6: begin
                    alpha = $urandom_range(0, 16777215);
                    vol = $urandom_range(0, 1023);
                    spk = $urandom_range(0, 1);
                    junk = 1'b1;
                end
                default: begin alpha = 8388608; vol = $urandom_range(0, 1023); spk = 0; end
            endcase

            // Reconfigure only with the block idle
            drain();
            write_reg(CFG_DC_ALPHA, ALPHA_W'(alpha));
            // Junk phases also put noise in the undecoded upper bits
            write_reg(CFG_VOLUME_MILLI,
                      junk ? {14'($urandom_range(0, 16383)), vol[VOL_W-1:0]}
                           : ALPHA_W'(vol));
            write_reg(CFG_SPEAKER_ONLY,
                      junk ? {23'($urandom_range(0, 8388607)), spk[0]}
                           : ALPHA_W'(spk));
            if (junk) write_reg(CFG_UNUSED, ALPHA_W'($urandom_range(0, 16777215)));

            burst = $urandom_range(1, 30);
            free_flow = $urandom_range(0, 3) == 0;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // Pause once per phase until the block has caught up
                if (n == PHASE_BEATS / 2) drain();
                random_beat(b);
                send_beat(b, 1'b0, '0);
                if (--burst == 0) begin
                    burst = $urandom_range(1, 30);
                    free_flow = $urandom_range(0, 3) == 0;
                    if (!free_flow)
                        idle_sender(($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                                : $urandom_range(1, 8));
                end
            end
        end

        drain();
        if (pending_samples.size() != 0)
            report($sformatf("%0d samples never arrived", pending_samples.size()));
        $display("Covered %0d beats and %0d checked samples across %0d register writes,",
                 beats_sent, samples_checked, cfg_writes);
        $display("including volume and alpha extremes, speaker-only and an undecoded index.");
        if (mismatches == 0) begin
            $display("stereo_audio_mixer_dc_block_test OK");
        end else begin
            $display("stereo_audio_mixer_dc_block_test NOT OK");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin : watchdog
        #4_000_000;
        $display("Timeout with %0d samples still owed", pending_samples.size());
        $display("stereo_audio_mixer_dc_block_test NOT OK");
        $finish;
    end

endmodule
